// ===== hdl/sitl_pkg.sv =====
// ----------------------------------------------------------------------------
// sitl_pkg
// Shared types and constants for the strip index to triangle list converter.
// ----------------------------------------------------------------------------
package sitl_pkg;

   // Default width of the per-buffer index counter
   localparam int COUNT_BITS_DEF = 28;

   // Configuration port
   localparam int CSR_DATA_W  = 28;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_INDICES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_MODE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LIMIT  = 2'd2;

   localparam int                  LIMIT_W     = 28;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 28'd1048576;

   // Buffer status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PARTIAL  = 2'd1;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd2;
   localparam logic [1:0] STATUS_LIST_REM = 2'd3;

   localparam logic [31:0] RESTART_WIDE   = 32'hFFFF_FFFF;
   localparam logic [31:0] RESTART_NARROW = 32'h0000_FFFF;

   // Index assembler result for the byte being transferred
   typedef struct packed {
      logic        done;     // an index completes with this byte
      logic [31:0] value;    // completed index, masked to the current width
      logic        partial;  // bytes of an unfinished index remain
   } idx_type;

endpackage

// ===== hdl/sitl_if.sv =====
// ----------------------------------------------------------------------------
// sitl_req_if / sitl_rsp_if
// Valid/ready channels for index bytes in and triangle/status results out.
// ----------------------------------------------------------------------------
interface sitl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sitl_rsp_if;
   logic        valid;
   logic        ready;
   logic        tri_valid;
   logic [31:0] vert_first;
   logic [31:0] vert_second;
   logic [31:0] vert_third;
   logic        buffer_done;
   logic [1:0]  status;

   modport source (output valid, output tri_valid, output vert_first,
                   output vert_second, output vert_third, output buffer_done,
                   output status, input ready);
   modport sink   (input valid, input tri_valid, input vert_first,
                   input vert_second, input vert_third, input buffer_done,
                   input status, output ready);
endinterface

// ===== hdl/sitl_index_asm.sv =====
// ----------------------------------------------------------------------------
// sitl_index_asm
// Builds big-endian 16- or 32-bit indices from a byte stream.
// ----------------------------------------------------------------------------
module sitl_index_asm
   import sitl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,       // a byte is transferred this cycle
   input  logic       last,       // that byte ends the buffer
   input  logic       wide,
   input  logic [7:0] data_byte,
   output idx_type    idx
);

   logic [31:0] accum_ff, accum_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] accum_next;
   logic [1:0]  pos_next;
   logic        complete;

   always_comb begin
      accum_next = {accum_ff[23:0], data_byte};
      pos_next   = pos_ff + 2'd1;
      // narrow indices finish at two bytes (or more if width changed mid-index)
      complete   = (pos_next == 2'd0) || (!wide && pos_next[1]);

      idx.done    = complete;
      idx.value   = wide ? accum_next : {16'h0000, accum_next[15:0]};
      idx.partial = !complete;

      accum_in = accum_ff;
      pos_in   = pos_ff;
      if (step) begin
         if (complete || last) begin
            accum_in = '0;
            pos_in   = '0;
         end else begin
            accum_in = accum_next;
            pos_in   = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         pos_ff   <= '0;
      end else begin
         accum_ff <= accum_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ===== hdl/strip_index_to_triangle_list.sv =====
// ----------------------------------------------------------------------------
// strip_index_to_triangle_list
// Turns a byte stream of list or strip indices into triangles plus a status.
// Latency: a byte transfer's result is captured in the output register.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Reset: synchronous; restores config defaults, clears buffer state and valid.
// ----------------------------------------------------------------------------
module strip_index_to_triangle_list
   import sitl_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   sitl_req_if.sink               req_chan,
   sitl_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CMP_W = (COUNT_BITS + 1 > LIMIT_W) ? COUNT_BITS + 1 : LIMIT_W;

   // configuration
   logic               wide_ff;
   logic               strip_ff;
   logic [LIMIT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff  <= 1'b0;
         strip_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDE_INDICES: wide_ff  <= csr_wdata[0];
            CSR_STRIP_MODE:   strip_ff <= csr_wdata[0];
            CSR_INDEX_LIMIT:  limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic rsp_valid_ff, rsp_valid_in;
   logic load;
   logic fire;

   assign load           = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = load;
   assign fire           = req_chan.valid && load;

   idx_type idx;

   sitl_index_asm u_asm (
      .clock     (clock),
      .reset     (reset),
      .step      (fire),
      .last      (req_chan.last_byte),
      .wide      (wide_ff),
      .data_byte (req_chan.data_byte),
      .idx       (idx)
   );

   // buffer state
   logic [31:0]           older_ff, older_in;
   logic [31:0]           newer_ff, newer_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  odd_ff, odd_in;
   logic [1:0]            slot_ff, slot_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  hit_ff, hit_in;

   logic                  emit;
   logic [31:0]           t0, t1, t2;
   logic [1:0]            status;
   logic [31:0]           v, restart;
   logic [CMP_W-1:0]      cnt_ext, lim_ext;

   always_comb begin
      older_in = older_ff;
      newer_in = newer_ff;
      fill_in  = fill_ff;
      odd_in   = odd_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      emit     = 1'b0;
      t0       = '0;
      t1       = '0;
      t2       = '0;
      status   = STATUS_OK;

      v       = idx.value;
      restart = wide_ff ? RESTART_WIDE : RESTART_NARROW;
      cnt_ext = CMP_W'(count_ff) + CMP_W'(1);
      lim_ext = CMP_W'(limit_ff);

      if (fire && idx.done && !hit_ff) begin
         if (cnt_ext > lim_ext) begin
            hit_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_BITS'(1);
            if (!strip_ff) begin
               case (slot_ff)
                  2'd0: begin
                     older_in = v;
                     slot_in  = 2'd1;
                  end
                  2'd1: begin
                     newer_in = v;
                     slot_in  = 2'd2;
                  end
                  default: begin
                     emit    = 1'b1;
                     t0      = older_ff;
                     t1      = newer_ff;
                     t2      = v;
                     slot_in = 2'd0;
                  end
               endcase
            end else if (v == restart) begin
               fill_in = 2'd0;
               odd_in  = 1'b0;
            end else begin
               // degenerate triangles are skipped, winding still advances
               if (fill_ff[1] && older_ff != newer_ff && newer_ff != v &&
                   older_ff != v) begin
                  emit = 1'b1;
                  t0   = older_ff;
                  t1   = odd_ff ? v : newer_ff;
                  t2   = odd_ff ? newer_ff : v;
               end
               older_in = newer_ff;
               newer_in = v;
               fill_in  = fill_ff[1] ? 2'd2 : fill_ff + 2'd1;
               odd_in   = !odd_ff;
            end
         end
      end

      if (fire && req_chan.last_byte) begin
         if (idx.partial)
            status = STATUS_PARTIAL;
         else if (hit_in)
            status = STATUS_TOO_MANY;
         else if (slot_in != 2'd0)
            status = STATUS_LIST_REM;
         older_in = '0;
         newer_in = '0;
         fill_in  = '0;
         odd_in   = 1'b0;
         slot_in  = '0;
         count_in = '0;
         hit_in   = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load)
         rsp_valid_in = fire && (emit || req_chan.last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff     <= '0;
         newer_ff     <= '0;
         fill_ff      <= '0;
         odd_ff       <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         fill_ff      <= fill_in;
         odd_ff       <= odd_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register
   logic        tri_ff;
   logic [31:0] first_ff, second_ff, third_ff;
   logic        done_ff;
   logic [1:0]  status_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tri_ff    <= emit;
         first_ff  <= t0;
         second_ff <= t1;
         third_ff  <= t2;
         done_ff   <= req_chan.last_byte;
         status_ff <= status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tri_valid   = tri_ff;
   assign rsp_chan.vert_first  = first_ff;
   assign rsp_chan.vert_second = second_ff;
   assign rsp_chan.vert_third  = third_ff;
   assign rsp_chan.buffer_done = done_ff;
   assign rsp_chan.status      = status_ff;

endmodule
